// ----- sv/video_ppu_register_port_assert.svh -----
// Assertion macros for the picture processing unit register port.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef VIDEO_PPU_REGISTER_PORT_ASSERT_SVH
`define VIDEO_PPU_REGISTER_PORT_ASSERT_SVH

`ifndef SYNTH

`define VPR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vpr assertion failed");

`define VPR_ASSERT_IMPLIES(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("vpr assertion failed");

`else

`define VPR_ASSERT(name, prop)

`define VPR_ASSERT_IMPLIES(name, pre, post)

`endif

`endif

// ----- sv/vpr_pkg.sv -----
package vpr_pkg;

  localparam int unsigned LINES_PER_FRAME = 262;
  localparam int unsigned SPRITE_BYTES    = 256;
  localparam int unsigned SPRITE_AW       = $clog2(SPRITE_BYTES);

  // Both queues hold a power-of-two number of transactions.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned LINE_W = 9;
  localparam int unsigned VA_W   = 14;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_SPR_ADDR = 3'd3;
  localparam logic [2:0] REG_SPR_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [VA_W-1:0] PALETTE_BASE = 14'h3F00;
  localparam logic [VA_W-1:0] STEP_ROW     = 14'd32;
  localparam logic [VA_W-1:0] STEP_ONE     = 14'd1;

  localparam logic [LINE_W-1:0] LINE_FIRST    = 9'd0;
  localparam logic [LINE_W-1:0] LINE_HIT_FROM = 9'd20;
  localparam logic [LINE_W-1:0] LINE_VBLANK   = 9'd261;

  localparam int unsigned FLAG_VBLANK   = 2;
  localparam int unsigned FLAG_HIT      = 1;
  localparam int unsigned FLAG_OVER     = 0;
  localparam int unsigned CTRL_NMI_BIT  = 7;
  localparam int unsigned CTRL_STEP_BIT = 2;
  localparam int unsigned MASK_HIT_BIT  = 4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD_STATUS,
    OP_RD_SPRITE,
    OP_RD_DATA,
    OP_RD_BAD,
    OP_WR_CTRL,
    OP_WR_MASK,
    OP_WR_SPR_ADDR,
    OP_WR_SPRITE,
    OP_WR_SCROLL,
    OP_WR_ADDR,
    OP_WR_DATA,
    OP_WR_BAD,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] wdata;
    logic [7:0] vdata;
    logic [7:0] vbelow;
  } cmd_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic [VA_W-1:0]   vram_address;
    logic              vram_write;
    logic [7:0]        vram_write_data;
    logic              nmi;
    logic              bad_register;
    logic [LINE_W-1:0] current_line;
    logic [7:0]        scroll_x;
    logic [7:0]        scroll_y;
    logic [7:0]        control;
    logic [7:0]        mask;
  } result_t;

endpackage

// ----- sv/vpr_ram.sv -----
module vpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/vpr_front.sv -----
module vpr_front import vpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] command_i,
  input  logic [2:0] register_select_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] vram_data_i,
  input  logic [7:0] vram_data_below_i,
  output cmd_t       head_o,
  output logic       head_valid_o,
  input  logic       head_pop_i
);

  op_e               op;
  cmd_t              entry;
  cmd_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              accept;
  logic              take;

  always_comb begin
    op = OP_NONE;
    case (command_i)
      CMD_READ: begin
        case (register_select_i)
          REG_STATUS:   op = OP_RD_STATUS;
          REG_SPR_DATA: op = OP_RD_SPRITE;
          REG_DATA:     op = OP_RD_DATA;
          default:      op = OP_RD_BAD;
        endcase
      end
      CMD_WRITE: begin
        case (register_select_i)
          REG_CTRL:     op = OP_WR_CTRL;
          REG_MASK:     op = OP_WR_MASK;
          REG_SPR_ADDR: op = OP_WR_SPR_ADDR;
          REG_SPR_DATA: op = OP_WR_SPRITE;
          REG_SCROLL:   op = OP_WR_SCROLL;
          REG_ADDR:     op = OP_WR_ADDR;
          REG_DATA:     op = OP_WR_DATA;
          default:      op = OP_WR_BAD;
        endcase
      end
      CMD_TICK: op = OP_TICK;
      default:  op = OP_NONE;
    endcase
  end

  assign entry = '{op: op, wdata: write_data_i, vdata: vram_data_i,
                   vbelow: vram_data_below_i};

  assign full         = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = queue_q[rd_ptr_q];
  assign accept       = push && !full;
  assign take         = head_pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = accept ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = take ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(accept) - QCNT_W'(take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      queue_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ----- sv/vpr_back.sv -----
module vpr_back import vpr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    head_i,
  input  logic    head_valid_i,
  output logic    head_pop_o,
  output result_t res_o,
  output logic    empty,
  input  logic    pop
);

  logic [7:0]          ctrl_q, ctrl_d;
  logic [7:0]          mask_q, mask_d;
  logic [2:0]          flags_q, flags_d;
  logic [7:0]          lw_q, lw_d;
  logic                toggle_q, toggle_d;
  logic [7:0]          sx_q, sx_d;
  logic [7:0]          sy_q, sy_d;
  logic [7:0]          ptr_q, ptr_d;
  logic [VA_W-1:0]     va_q, va_d;
  logic [7:0]          buf_q, buf_d;
  logic [LINE_W-1:0]   line_q, line_d;
  logic [SPRITE_BYTES-1:0] spr_valid_q, spr_valid_d;

  logic [VA_W-1:0]     va_adv;
  logic [LINE_W:0]     line_inc;
  logic                fire;
  logic                s2_move;
  logic                ram_we;
  logic                ram_re;
  logic [7:0]          ram_rdata;
  logic                spr_rd;
  result_t             res;

  logic                s2_valid_q, s2_valid_d;
  result_t             s2_res_q;
  logic                s2_spr_q;
  logic                s2_hit_q;
  result_t             s2_out;

  result_t             out_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   out_wr_q, out_wr_d;
  logic [QPTR_W-1:0]   out_rd_q, out_rd_d;
  logic [QCNT_W-1:0]   out_cnt_q, out_cnt_d;
  logic                out_take;

  assign s2_move    = s2_valid_q && (out_cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign fire       = head_valid_i && (!s2_valid_q || s2_move);
  assign head_pop_o = fire;

  assign va_adv   = va_q + (ctrl_q[CTRL_STEP_BIT] ? STEP_ROW : STEP_ONE);
  assign line_inc = (LINE_W + 1)'(line_q) + (LINE_W + 1)'(1);

  always_comb begin
    ctrl_d      = ctrl_q;
    mask_d      = mask_q;
    flags_d     = flags_q;
    lw_d        = lw_q;
    toggle_d    = toggle_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    ptr_d       = ptr_q;
    va_d        = va_q;
    buf_d       = buf_q;
    line_d      = line_q;
    spr_valid_d = spr_valid_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    spr_rd      = 1'b0;
    res         = '0;
    res.vram_address = va_q;
    if (fire) begin
      case (head_i.op)
        OP_RD_STATUS: begin
          res.read_data       = {flags_q, lw_q[4:0]};
          flags_d[FLAG_VBLANK] = 1'b0;
          toggle_d            = 1'b0;
        end
        OP_RD_SPRITE: begin
          ram_re = 1'b1;
          spr_rd = 1'b1;
          ptr_d  = ptr_q + 8'd1;
        end
        OP_RD_DATA: begin
          if (va_q < PALETTE_BASE) begin
            res.read_data = buf_q;
            buf_d         = head_i.vdata;
          end else begin
            res.read_data = head_i.vdata;
            buf_d         = head_i.vbelow;
          end
          va_d = va_adv;
        end
        OP_RD_BAD: res.bad_register = 1'b1;
        OP_WR_CTRL: begin
          ctrl_d  = head_i.wdata;
          res.nmi = flags_q[FLAG_VBLANK] && head_i.wdata[CTRL_NMI_BIT];
          lw_d    = head_i.wdata;
        end
        OP_WR_MASK: begin
          mask_d = head_i.wdata;
          lw_d   = head_i.wdata;
        end
        OP_WR_SPR_ADDR: begin
          ptr_d = head_i.wdata;
          lw_d  = head_i.wdata;
        end
        OP_WR_SPRITE: begin
          ram_we                         = 1'b1;
          spr_valid_d[ptr_q[SPRITE_AW-1:0]] = 1'b1;
          ptr_d                          = ptr_q + 8'd1;
          lw_d                           = head_i.wdata;
        end
        OP_WR_SCROLL: begin
          if (!toggle_q) begin
            sx_d = head_i.wdata;
          end else begin
            sy_d = head_i.wdata;
          end
          toggle_d = !toggle_q;
          lw_d     = head_i.wdata;
        end
        OP_WR_ADDR: begin
          if (!toggle_q) begin
            va_d = {head_i.wdata[5:0], va_q[7:0]};
          end else begin
            va_d = {va_q[VA_W-1:8], head_i.wdata};
          end
          toggle_d = !toggle_q;
          lw_d     = head_i.wdata;
        end
        OP_WR_DATA: begin
          res.vram_write      = 1'b1;
          res.vram_write_data = head_i.wdata;
          va_d                = va_adv;
          lw_d                = head_i.wdata;
        end
        OP_WR_BAD: begin
          res.bad_register = 1'b1;
          lw_d             = head_i.wdata;
        end
        OP_TICK: begin
          if (line_q == LINE_FIRST) begin
            flags_d[FLAG_HIT]  = 1'b0;
            flags_d[FLAG_OVER] = 1'b0;
          end
          if (line_q > LINE_HIT_FROM && line_q < LINE_VBLANK && mask_q[MASK_HIT_BIT]) begin
            flags_d[FLAG_HIT] = 1'b1;
          end
          if (line_q == LINE_VBLANK) begin
            flags_d[FLAG_VBLANK] = 1'b1;
            res.nmi              = ctrl_q[CTRL_NMI_BIT];
          end
          line_d = (line_inc == (LINE_W + 1)'(LINES_PER_FRAME)) ? '0 : line_inc[LINE_W-1:0];
        end
        default: begin
          res.bad_register = 1'b0;
        end
      endcase
    end
    res.current_line = line_d;
    res.scroll_x     = sx_d;
    res.scroll_y     = sy_d;
    res.control      = ctrl_d;
    res.mask         = mask_d;
  end

  vpr_ram #(
    .WIDTH (8),
    .DEPTH (SPRITE_BYTES)
  ) u_sprite_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q[SPRITE_AW-1:0]),
    .wdata_i (head_i.wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q[SPRITE_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      mask_q      <= '0;
      flags_q     <= '0;
      lw_q        <= '0;
      toggle_q    <= 1'b0;
      sx_q        <= '0;
      sy_q        <= '0;
      ptr_q       <= '0;
      va_q        <= '0;
      buf_q       <= '0;
      line_q      <= '0;
      spr_valid_q <= '0;
      s2_valid_q  <= 1'b0;
    end else begin
      ctrl_q      <= ctrl_d;
      mask_q      <= mask_d;
      flags_q     <= flags_d;
      lw_q        <= lw_d;
      toggle_q    <= toggle_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      ptr_q       <= ptr_d;
      va_q        <= va_d;
      buf_q       <= buf_d;
      line_q      <= line_d;
      spr_valid_q <= spr_valid_d;
      s2_valid_q  <= s2_valid_d;
    end
  end

  assign s2_valid_d = fire ? 1'b1 : (s2_move ? 1'b0 : s2_valid_q);

  // The sprite byte arrives from the memory in the cycle after the read is issued.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      s2_res_q <= res;
      s2_spr_q <= spr_rd;
      s2_hit_q <= spr_valid_q[ptr_q[SPRITE_AW-1:0]];
    end
  end

  always_comb begin
    s2_out = s2_res_q;
    if (s2_spr_q) begin
      s2_out.read_data = s2_hit_q ? ram_rdata : 8'd0;
    end
  end

  assign empty    = (out_cnt_q == '0);
  assign out_take = pop && !empty;
  assign res_o    = out_q[out_rd_q];

  always_comb begin
    out_wr_d  = s2_move ? out_wr_q + QPTR_W'(1) : out_wr_q;
    out_rd_d  = out_take ? out_rd_q + QPTR_W'(1) : out_rd_q;
    out_cnt_d = out_cnt_q + QCNT_W'(s2_move) - QCNT_W'(out_take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      out_wr_q  <= out_wr_d;
      out_rd_q  <= out_rd_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_q[out_wr_q] <= s2_out;
    end
  end

endmodule

// ----- sv/video_ppu_register_port.sv -----
// Channel  Direction  Handshake          Payload
// request  in         push / full        command, register_select, write_data,
//                                        vram_data, vram_data_below
// result   out        empty / pop        read_data, vram_address, vram_write, ...
//
// One transaction is taken every cycle while full is low; its result passes through
// the front queue, the execute stage and the output queue before it can be popped.
// Reset clears the state registers, queue pointers and sprite valid bits at once.
// Full rises while two transactions wait between the front and the back, and the
// back stalls while two results wait in the output queue.
`include "video_ppu_register_port_assert.svh"

module video_ppu_register_port import vpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           command_i,
  input  logic [2:0]           register_select_i,
  input  logic [7:0]           write_data_i,
  input  logic [7:0]           vram_data_i,
  input  logic [7:0]           vram_data_below_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           read_data_o,
  output logic [VA_W-1:0]      vram_address_o,
  output logic                 vram_write_o,
  output logic [7:0]           vram_write_data_o,
  output logic                 nmi_o,
  output logic                 bad_register_o,
  output logic [LINE_W-1:0]    current_line_o,
  output logic [7:0]           scroll_x_out_o,
  output logic [7:0]           scroll_y_out_o,
  output logic [7:0]           control_out_o,
  output logic [7:0]           mask_out_o
);

  cmd_t    head;
  logic    head_valid;
  logic    head_pop;
  result_t res;

  vpr_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .command_i         (command_i),
    .register_select_i (register_select_i),
    .write_data_i      (write_data_i),
    .vram_data_i       (vram_data_i),
    .vram_data_below_i (vram_data_below_i),
    .head_o            (head),
    .head_valid_o      (head_valid),
    .head_pop_i        (head_pop)
  );

  vpr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .res_o        (res),
    .empty        (empty),
    .pop          (pop)
  );

  assign read_data_o       = res.read_data;
  assign vram_address_o    = res.vram_address;
  assign vram_write_o      = res.vram_write;
  assign vram_write_data_o = res.vram_write_data;
  assign nmi_o             = res.nmi;
  assign bad_register_o    = res.bad_register;
  assign current_line_o    = res.current_line;
  assign scroll_x_out_o    = res.scroll_x;
  assign scroll_y_out_o    = res.scroll_y;
  assign control_out_o     = res.control;
  assign mask_out_o        = res.mask;

  `VPR_ASSERT_IMPLIES(a_write_quiet, !empty && vram_write_o, read_data_o == 8'd0 && !bad_register_o && !nmi_o)
  `VPR_ASSERT_IMPLIES(a_bad_quiet, !empty && bad_register_o, read_data_o == 8'd0 && !vram_write_o && !nmi_o)
  `VPR_ASSERT_IMPLIES(a_wdata_gated, !empty && !vram_write_o, vram_write_data_o == 8'd0)
  `VPR_ASSERT(a_line_range, empty || (10'(current_line_o) < 10'(LINES_PER_FRAME)))

endmodule

// ----- tb/video_ppu_register_port_tb.sv -----
module video_ppu_register_port_tb;
  import vpr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [1:0]           command_i = '0;
  logic [2:0]           register_select_i = '0;
  logic [7:0]           write_data_i = '0;
  logic [7:0]           vram_data_i = '0;
  logic [7:0]           vram_data_below_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [7:0]           read_data_o;
  logic [VA_W-1:0]      vram_address_o;
  logic                 vram_write_o;
  logic [7:0]           vram_write_data_o;
  logic                 nmi_o;
  logic                 bad_register_o;
  logic [LINE_W-1:0]    current_line_o;
  logic [7:0]           scroll_x_out_o;
  logic [7:0]           scroll_y_out_o;
  logic [7:0]           control_out_o;
  logic [7:0]           mask_out_o;

  video_ppu_register_port u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .command_i         (command_i),
    .register_select_i (register_select_i),
    .write_data_i      (write_data_i),
    .vram_data_i       (vram_data_i),
    .vram_data_below_i (vram_data_below_i),
    .empty             (empty),
    .pop               (pop),
    .read_data_o       (read_data_o),
    .vram_address_o    (vram_address_o),
    .vram_write_o      (vram_write_o),
    .vram_write_data_o (vram_write_data_o),
    .nmi_o             (nmi_o),
    .bad_register_o    (bad_register_o),
    .current_line_o    (current_line_o),
    .scroll_x_out_o    (scroll_x_out_o),
    .scroll_y_out_o    (scroll_y_out_o),
    .control_out_o     (control_out_o),
    .mask_out_o        (mask_out_o)
  );

  logic [7:0]        ppu_ctrl = '0;
  logic [7:0]        ppu_mask = '0;
  logic [2:0]        ppu_flags = '0;
  logic [7:0]        ppu_last_wr = '0;
  logic              ppu_toggle = 1'b0;
  logic [7:0]        model_scroll_x = '0;
  logic [7:0]        model_scroll_y = '0;
  logic [7:0]        oam_ptr = '0;
  logic [7:0]        oam_mem [SPRITE_BYTES];
  logic [VA_W-1:0]   vaddr = '0;
  logic [7:0]        data_buffer = '0;
  logic [LINE_W-1:0] scanline = '0;

  result_t pending_results [$];
  logic    no_idle = 1'b0;
  int      error_count = 0;
  int      items_sent = 0;
  int      results_checked = 0;
  int      frames_seen = 0;
  int      nmi_predicted = 0;

  initial begin
    foreach (oam_mem[i]) oam_mem[i] = '0;
  end

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void step_vaddr();
    vaddr = vaddr + (ppu_ctrl[CTRL_STEP_BIT] ? STEP_ROW : STEP_ONE);
  endfunction

  function automatic result_t compute_access(input logic [1:0] cmd, input logic [2:0] sel,
                                             input logic [7:0] wd, input logic [7:0] vd,
                                             input logic [7:0] vb);
    result_t r;
    r = '0;
    r.vram_address = vaddr;
    case (cmd)
      CMD_READ: begin
        case (sel)
          REG_STATUS: begin
            r.read_data = {ppu_flags, ppu_last_wr[4:0]};
            ppu_flags[FLAG_VBLANK] = 1'b0;
            ppu_toggle = 1'b0;
          end
          REG_SPR_DATA: begin
            r.read_data = oam_mem[oam_ptr];
            oam_ptr = oam_ptr + 8'd1;
          end
          REG_DATA: begin
            if (vaddr < PALETTE_BASE) begin
              r.read_data = data_buffer;
              data_buffer = vd;
            end else begin
              r.read_data = vd;
              data_buffer = vb;
            end
            step_vaddr();
          end
          default: r.bad_register = 1'b1;
        endcase
      end
      CMD_WRITE: begin
        case (sel)
          REG_CTRL: begin
            ppu_ctrl = wd;
            r.nmi = ppu_flags[FLAG_VBLANK] & wd[CTRL_NMI_BIT];
          end
          REG_MASK: ppu_mask = wd;
          REG_SPR_ADDR: oam_ptr = wd;
          REG_SPR_DATA: begin
            oam_mem[oam_ptr] = wd;
            oam_ptr = oam_ptr + 8'd1;
          end
          REG_SCROLL: begin
            if (!ppu_toggle) model_scroll_x = wd;
            else model_scroll_y = wd;
            ppu_toggle = ~ppu_toggle;
          end
          REG_ADDR: begin
            if (!ppu_toggle) vaddr = {wd[5:0], vaddr[7:0]};
            else vaddr = {vaddr[13:8], wd};
            ppu_toggle = ~ppu_toggle;
          end
          REG_DATA: begin
            r.vram_write = 1'b1;
            r.vram_write_data = wd;
            step_vaddr();
          end
          default: r.bad_register = 1'b1;
        endcase
        ppu_last_wr = wd;
      end
      CMD_TICK: begin
        if (scanline == LINE_FIRST) begin
          ppu_flags[FLAG_HIT] = 1'b0;
          ppu_flags[FLAG_OVER] = 1'b0;
        end
        if (scanline > LINE_HIT_FROM && scanline < LINE_VBLANK && ppu_mask[MASK_HIT_BIT])
          ppu_flags[FLAG_HIT] = 1'b1;
        if (scanline == LINE_VBLANK) begin
          ppu_flags[FLAG_VBLANK] = 1'b1;
          r.nmi = ppu_ctrl[CTRL_NMI_BIT];
          frames_seen++;
        end
        scanline = LINE_W'((int'(scanline) + 1) % LINES_PER_FRAME);
      end
      default: ;
    endcase
    if (r.nmi) nmi_predicted++;
    r.current_line = scanline;
    r.scroll_x = model_scroll_x;
    r.scroll_y = model_scroll_y;
    r.control = ppu_ctrl;
    r.mask = ppu_mask;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result transaction, read_data", 16'(read_data_o), '0);
      return;
    end
    want = pending_results.pop_front();
    check_field("read_data", 16'(read_data_o), 16'(want.read_data));
    check_field("vram_address", 16'(vram_address_o), 16'(want.vram_address));
    check_field("vram_write", 16'(vram_write_o), 16'(want.vram_write));
    check_field("vram_write_data", 16'(vram_write_data_o), 16'(want.vram_write_data));
    check_field("nmi", 16'(nmi_o), 16'(want.nmi));
    check_field("bad_register", 16'(bad_register_o), 16'(want.bad_register));
    check_field("current_line", 16'(current_line_o), 16'(want.current_line));
    check_field("scroll_x", 16'(scroll_x_out_o), 16'(want.scroll_x));
    check_field("scroll_y", 16'(scroll_y_out_o), 16'(want.scroll_y));
    check_field("control", 16'(control_out_o), 16'(want.control));
    check_field("mask", 16'(mask_out_o), 16'(want.mask));
    results_checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_result();
      pop <= no_idle || ($urandom_range(0, 99) >= 25);
    end
  end

  task automatic send_access(input logic [1:0] cmd, input logic [2:0] sel,
                             input logic [7:0] wd);
    logic [7:0] vd;
    logic [7:0] vb;
    vd = 8'($urandom);
    vb = 8'($urandom);
    while (!no_idle && $urandom_range(0, 99) < 25) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd;
    register_select_i <= sel;
    write_data_i <= wd;
    vram_data_i <= vd;
    vram_data_below_i <= vb;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_results.push_back(compute_access(cmd, sel, wd, vd, vb));
    items_sent++;
  endtask

  task automatic test_directed_registers();
    send_access(CMD_READ, REG_STATUS, 8'h00);
    send_access(CMD_WRITE, REG_CTRL, 8'h04);
    send_access(CMD_WRITE, REG_ADDR, 8'hFF);
    send_access(CMD_WRITE, REG_ADDR, 8'hFF);
    send_access(CMD_READ, REG_DATA, 8'h00);
    send_access(CMD_WRITE, REG_CTRL, 8'h00);
    send_access(CMD_WRITE, REG_DATA, 8'hFF);
    send_access(CMD_READ, REG_DATA, 8'h00);
    send_access(CMD_READ, REG_DATA, 8'h00);
    send_access(CMD_WRITE, REG_SPR_ADDR, 8'hFF);
    send_access(CMD_WRITE, REG_SPR_DATA, 8'hA5);
    send_access(CMD_WRITE, REG_SPR_ADDR, 8'hFF);
    send_access(CMD_READ, REG_SPR_DATA, 8'h00);
    send_access(CMD_WRITE, REG_SCROLL, 8'hFF);
    send_access(CMD_WRITE, REG_SCROLL, 8'h80);
    send_access(CMD_WRITE, REG_MASK, 8'hFF);
    send_access(CMD_READ, REG_STATUS, 8'h00);
    send_access(CMD_WRITE, REG_STATUS, 8'h5A);
    send_access(CMD_READ, REG_CTRL, 8'h00);
    send_access(CMD_READ, REG_MASK, 8'h00);
    send_access(CMD_READ, REG_SPR_ADDR, 8'h00);
    send_access(CMD_READ, REG_SCROLL, 8'h00);
    send_access(CMD_READ, REG_ADDR, 8'h00);
    send_access(CMD_UNUSED, REG_DATA, 8'hFF);
    send_access(CMD_TICK, REG_CTRL, 8'h00);
  endtask

  task automatic test_frame_timing();
    logic [7:0] v;
    int         pick;
    send_access(CMD_WRITE, REG_MASK, 8'h10);
    send_access(CMD_WRITE, REG_CTRL, 8'h80);
    repeat (700) begin
      pick = $urandom_range(0, 99);
      v = 8'($urandom);
      if (pick < 75) send_access(CMD_TICK, 3'($urandom), v);
      else if (pick < 83) send_access(CMD_READ, REG_STATUS, v);
      else if (pick < 89) send_access(CMD_WRITE, REG_CTRL, v);
      else if (pick < 94) send_access(CMD_WRITE, REG_MASK, v);
      else send_access(2'($urandom_range(0, 1)), 3'($urandom), v);
    end
  endtask

  task automatic test_video_memory();
    logic [7:0] hi;
    repeat (50) begin
      if ($urandom_range(0, 9) != 0) send_access(CMD_READ, REG_STATUS, 8'($urandom));
      send_access(CMD_WRITE, REG_CTRL, 8'($urandom));
      hi = ($urandom_range(0, 3) == 0) ? {2'($urandom), 6'h3F} : 8'($urandom);
      send_access(CMD_WRITE, REG_ADDR, hi);
      if ($urandom_range(0, 9) != 0) send_access(CMD_WRITE, REG_ADDR, 8'($urandom));
      repeat ($urandom_range(1, 6))
        send_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, REG_DATA, 8'($urandom));
    end
  endtask

  task automatic test_sprite_store();
    logic [7:0] start;
    int         n;
    no_idle = 1'b1;
    repeat (25) begin
      start = 8'($urandom);
      n = $urandom_range(1, 5);
      send_access(CMD_WRITE, REG_SPR_ADDR, start);
      repeat (n) send_access(CMD_WRITE, REG_SPR_DATA, 8'($urandom));
      send_access(CMD_WRITE, REG_SPR_ADDR, start);
      repeat (n) send_access(CMD_READ, REG_SPR_DATA, 8'($urandom));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_access();
    repeat (300) send_access(2'($urandom), 3'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_registers();
    test_frame_timing();
    test_video_memory();
    test_sprite_store();
    test_random_access();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d register accesses and scanline ticks; checked %0d results.",
             items_sent, results_checked);
    $display("Frames reaching vblank: %0d; interrupts predicted: %0d; mismatches: %0d.",
             frames_seen, nmi_predicted, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
